### rtl/itf_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and segment codes for the integer to text formatter.
// No dependencies; used by itf_ctrl, itf_datapath and integer_to_text_formatter.
package itf_pkg;

   localparam int VALUE_W  = 32;
   localparam int BASE_W   = 6;
   localparam int LEN_IN_W = 7;
   localparam int FLAGS_W  = 7;
   localparam int CHAR_W   = 8;

   // format flag bit positions
   localparam int FL_ZERO  = 0;
   localparam int FL_SIGN  = 1;
   localparam int FL_PLUS  = 2;
   localparam int FL_SPACE = 3;
   localparam int FL_LEFT  = 4;
   localparam int FL_ALT   = 5;
   localparam int FL_LOWER = 6;

   // restoring divider: quotient bits per cycle
   localparam int DIV_BITS   = 8;
   localparam int DIV_CHUNKS = VALUE_W / DIV_BITS;
   localparam int CHUNK_W    = $clog2(DIV_CHUNKS);
   localparam int REM_W      = BASE_W;
   localparam int DEC_RADIX  = 10;

   localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
   localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
   localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
   localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

   // text segments, in output order
   localparam int SEG_W   = 3;
   localparam int NUM_SEG = 8;
   localparam logic [SEG_W-1:0] SEG_LEAD  = 3'd0;
   localparam logic [SEG_W-1:0] SEG_SIGN  = 3'd1;
   localparam logic [SEG_W-1:0] SEG_PFX0  = 3'd2;
   localparam logic [SEG_W-1:0] SEG_PFX1  = 3'd3;
   localparam logic [SEG_W-1:0] SEG_ZPAD  = 3'd4;
   localparam logic [SEG_W-1:0] SEG_PZERO = 3'd5;
   localparam logic [SEG_W-1:0] SEG_DIGIT = 3'd6;
   localparam logic [SEG_W-1:0] SEG_TRAIL = 3'd7;

   localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_A_UPPER = 8'h41;
   localparam logic [CHAR_W-1:0] CH_X_UPPER = 8'h58;
   localparam logic [CHAR_W-1:0] CH_A_LOWER = 8'h61;
   localparam logic [CHAR_W-1:0] CH_X_LOWER = 8'h78;

   typedef struct packed {
      logic             load;
      logic             div_step;
      logic             plan;
      logic             emit;
      logic             emit_bad;
      logic             last;
      logic [SEG_W-1:0] seg;
   } itf_cmd_type;

   typedef struct packed {
      logic               req_bad;
      logic               div_last;
      logic               out_free;
      logic               total_one;
      logic [NUM_SEG-1:0] seg_busy;
      logic [NUM_SEG-1:0] seg_end;
   } itf_status_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d,
                                                    input logic lower);
      logic [CHAR_W-1:0] wide;
      logic [CHAR_W-1:0] alpha;
      wide  = CHAR_W'(d);
      alpha = lower ? CH_A_LOWER : CH_A_UPPER;
      if (d < REM_W'(DEC_RADIX)) begin
         return CH_ZERO + wide;
      end
      return alpha + wide - CHAR_W'(DEC_RADIX);
   endfunction

endpackage

### rtl/itf_ctrl.sv
`timescale 1ns / 1ps
// Controller for the integer to text formatter: sequences load, divide, plan and emit.
// Depends on itf_pkg; drives itf_datapath through itf_cmd_type.
module itf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  itf_pkg::itf_status_type status,
   output itf_pkg::itf_cmd_type    cmd
);
   import itf_pkg::*;

   localparam logic [3:0] ST_LEAD  = {1'b0, SEG_LEAD};
   localparam logic [3:0] ST_SIGN  = {1'b0, SEG_SIGN};
   localparam logic [3:0] ST_PFX0  = {1'b0, SEG_PFX0};
   localparam logic [3:0] ST_PFX1  = {1'b0, SEG_PFX1};
   localparam logic [3:0] ST_ZPAD  = {1'b0, SEG_ZPAD};
   localparam logic [3:0] ST_PZERO = {1'b0, SEG_PZERO};
   localparam logic [3:0] ST_DIGIT = {1'b0, SEG_DIGIT};
   localparam logic [3:0] ST_TRAIL = {1'b0, SEG_TRAIL};
   localparam logic [3:0] ST_IDLE  = 4'd8;
   localparam logic [3:0] ST_DIV   = 4'd9;
   localparam logic [3:0] ST_PLAN  = 4'd10;
   localparam logic [3:0] ST_START = 4'd11;
   localparam logic [3:0] ST_ERROR = 4'd12;

   logic [3:0]       state_ff;
   logic [3:0]       state_in;
   logic [SEG_W-1:0] first_seg;
   logic [SEG_W-1:0] after_seg;

   // first non-empty segment overall, and the first one after the current one
   always_comb begin
      first_seg = SEG_TRAIL;
      after_seg = SEG_TRAIL;
      for (int k = NUM_SEG - 1; k >= 0; k--) begin
         if (status.seg_busy[k]) begin
            first_seg = SEG_W'(k);
         end
         if (status.seg_busy[k] && (SEG_W'(k) > state_ff[SEG_W-1:0])) begin
            after_seg = SEG_W'(k);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff) inside
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.req_bad ? ST_ERROR : ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
            state_in = ST_START;
         end
         ST_START: begin
            state_in = {1'b0, first_seg};
         end
         ST_ERROR: begin
            if (status.out_free) begin
               cmd.emit_bad = 1'b1;
               cmd.last     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_LEAD, ST_SIGN, ST_PFX0, ST_PFX1, ST_ZPAD, ST_PZERO, ST_DIGIT, ST_TRAIL: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.seg  = state_ff[SEG_W-1:0];
               cmd.last = status.total_one;
               if (status.total_one) begin
                  state_in = ST_IDLE;
               end else if (status.seg_end[state_ff[SEG_W-1:0]]) begin
                  state_in = {1'b0, after_seg};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/itf_datapath.sv
`timescale 1ns / 1ps
// Datapath for the integer to text formatter: item registers, shared divider,
// digit buffer, segment counters and the result register. Depends on itf_pkg.
module itf_datapath #(
   parameter int MAX_FIELD          = 60,
   parameter int DIGIT_BUFFER_DEPTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  itf_pkg::itf_cmd_type               cmd,
   output itf_pkg::itf_status_type            status,
   input  logic        [itf_pkg::VALUE_W-1:0]  req_value,
   input  logic        [itf_pkg::BASE_W-1:0]   req_base,
   input  logic signed [itf_pkg::LEN_IN_W-1:0] req_width,
   input  logic signed [itf_pkg::LEN_IN_W-1:0] req_precision,
   input  logic        [itf_pkg::FLAGS_W-1:0]  req_format_flags,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic        [itf_pkg::CHAR_W-1:0]   rsp_text_char,
   output logic                               rsp_last_char,
   output logic                               rsp_bad_base
);
   import itf_pkg::*;

   localparam int ND_W  = $clog2(DIGIT_BUFFER_DEPTH + 1);
   localparam int IDX_W = $clog2(DIGIT_BUFFER_DEPTH);
   localparam int LEN_W = $clog2(MAX_FIELD + DIGIT_BUFFER_DEPTH + 4) + 1;

   function automatic logic signed [LEN_W-1:0] decode_len(input logic [LEN_IN_W-1:0] raw);
      logic [LEN_W-1:0] mag;
      mag = LEN_W'(raw[LEN_IN_W-2:0]);
      if (raw[LEN_IN_W-1]) begin
         return '1;
      end
      if (mag > LEN_W'(MAX_FIELD)) begin
         return LEN_W'(MAX_FIELD);
      end
      return mag;
   endfunction

   // per-item registers
   logic [BASE_W-1:0]       base_ff;
   logic                    lower_ff;
   logic                    zero_ff;
   logic                    left_ff;
   logic                    has_sign_ff;
   logic [CHAR_W-1:0]       sign_char_ff;
   logic [1:0]              alt_len_ff;
   logic signed [LEN_W-1:0] size_ff;
   logic signed [LEN_W-1:0] prec_ff;
   logic [REM_W-1:0]        digit_ff [DIGIT_BUFFER_DEPTH];

   // counters and working registers
   logic [VALUE_W-1:0] num_ff,   num_in;
   logic [REM_W-1:0]   rem_ff,   rem_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [ND_W-1:0]    nd_ff,    nd_in;
   logic [LEN_W-1:0]   pad_ff,   pad_in;
   logic [LEN_W-1:0]   pz_ff,    pz_in;
   logic [LEN_W-1:0]   total_ff, total_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] text_ff,      text_in;
   logic              last_ff,      last_in;
   logic              bad_ff,       bad_in;

   logic                    neg_in;
   logic                    has_sign_in;
   logic [CHAR_W-1:0]       sign_char_in;
   logic [1:0]              alt_len_in;
   logic [VALUE_W-1:0]      q_div;
   logic [REM_W-1:0]        r_div;
   logic [REM_W:0]          div_trial;
   logic                    digit_done;
   logic [ND_W-1:0]         nd_dec;
   logic signed [LEN_W-1:0] nd_len;
   logic signed [LEN_W-1:0] prec_eff;
   logic signed [LEN_W-1:0] body_len;
   logic signed [LEN_W-1:0] room;
   logic signed [LEN_W-1:0] pad_len;
   logic [CHAR_W-1:0]       emit_char;
   logic                    out_free;

   // sign and prefix of the incoming beat
   always_comb begin
      neg_in       = req_format_flags[FL_SIGN] & req_value[VALUE_W-1];
      has_sign_in  = 1'b1;
      sign_char_in = CH_MINUS;
      if (!neg_in) begin
         if (req_format_flags[FL_PLUS]) begin
            sign_char_in = CH_PLUS;
         end else if (req_format_flags[FL_SPACE]) begin
            sign_char_in = CH_SPACE;
         end else begin
            has_sign_in = 1'b0;
         end
      end
      alt_len_in = 2'd0;
      if (req_format_flags[FL_ALT]) begin
         if (req_base == BASE_HEX) begin
            alt_len_in = 2'd2;
         end else if (req_base == BASE_OCT) begin
            alt_len_in = 2'd1;
         end
      end
   end

   // restoring divider, DIV_BITS quotient bits per cycle
   always_comb begin
      q_div     = num_ff;
      r_div     = rem_ff;
      div_trial = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         div_trial = {r_div, q_div[VALUE_W-1]};
         q_div     = {q_div[VALUE_W-2:0], 1'b0};
         if (div_trial >= {1'b0, base_ff}) begin
            div_trial = div_trial - {1'b0, base_ff};
            q_div[0]  = 1'b1;
         end
         r_div = div_trial[REM_W-1:0];
      end
   end

   assign digit_done = (chunk_ff == CHUNK_W'(DIV_CHUNKS - 1));
   assign nd_dec     = nd_ff - ND_W'(1);

   // segment lengths
   always_comb begin
      nd_len   = LEN_W'(nd_ff);
      prec_eff = (prec_ff > nd_len) ? prec_ff : nd_len;
      body_len = prec_eff + $signed(LEN_W'(alt_len_ff)) + $signed(LEN_W'(has_sign_ff));
      room     = size_ff - body_len;
      pad_len  = (room > 0) ? room : '0;
   end

   always_comb begin
      case (cmd.seg) inside
         SEG_LEAD, SEG_TRAIL:            emit_char = CH_SPACE;
         SEG_SIGN:                       emit_char = sign_char_ff;
         SEG_PFX0, SEG_ZPAD, SEG_PZERO:  emit_char = CH_ZERO;
         SEG_PFX1:                       emit_char = lower_ff ? CH_X_LOWER : CH_X_UPPER;
         SEG_DIGIT:  emit_char = digit_char(digit_ff[nd_dec[IDX_W-1:0]], lower_ff);
         default:                        emit_char = CH_SPACE;
      endcase
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      num_in       = num_ff;
      rem_in       = rem_ff;
      chunk_in     = chunk_ff;
      nd_in        = nd_ff;
      pad_in       = pad_ff;
      pz_in        = pz_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      text_in      = text_ff;
      last_in      = last_ff;
      bad_in       = bad_ff;
      if (cmd.load) begin
         num_in   = neg_in ? ({VALUE_W{1'b0}} - req_value) : req_value;
         rem_in   = '0;
         chunk_in = '0;
         nd_in    = '0;
      end
      if (cmd.div_step) begin
         num_in   = q_div;
         chunk_in = chunk_ff + CHUNK_W'(1);
         rem_in   = digit_done ? '0 : r_div;
         if (digit_done) begin
            nd_in = nd_ff + ND_W'(1);
         end
      end
      if (cmd.plan) begin
         pad_in   = pad_len;
         pz_in    = prec_eff - nd_len;
         total_in = body_len + pad_len;
      end
      if (cmd.emit) begin
         total_in     = total_ff - LEN_W'(1);
         rsp_valid_in = 1'b1;
         text_in      = emit_char;
         last_in      = cmd.last;
         bad_in       = 1'b0;
         case (cmd.seg) inside
            SEG_LEAD, SEG_ZPAD, SEG_TRAIL: pad_in = pad_ff - LEN_W'(1);
            SEG_PZERO:                     pz_in  = pz_ff - LEN_W'(1);
            SEG_DIGIT:                     nd_in  = nd_dec;
            default:                       ;
         endcase
      end
      if (cmd.emit_bad) begin
         rsp_valid_in = 1'b1;
         text_in      = CH_NUL;
         last_in      = 1'b1;
         bad_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         chunk_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         chunk_ff     <= chunk_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      nd_ff    <= nd_in;
      pad_ff   <= pad_in;
      pz_ff    <= pz_in;
      total_ff <= total_in;
      text_ff  <= text_in;
      last_ff  <= last_in;
      bad_ff   <= bad_in;
      if (cmd.load) begin
         base_ff      <= req_base;
         lower_ff     <= req_format_flags[FL_LOWER];
         zero_ff      <= req_format_flags[FL_ZERO] & ~req_format_flags[FL_LEFT];
         left_ff      <= req_format_flags[FL_LEFT];
         has_sign_ff  <= has_sign_in;
         sign_char_ff <= sign_char_in;
         alt_len_ff   <= alt_len_in;
         size_ff      <= decode_len(req_width);
         prec_ff      <= decode_len(req_precision);
      end
      if (cmd.div_step && digit_done) begin
         digit_ff[nd_ff[IDX_W-1:0]] <= r_div;
      end
   end

   always_comb begin
      status.req_bad   = (req_base < BASE_MIN) || (req_base > BASE_MAX);
      status.div_last  = digit_done && ((q_div == '0) ||
                         (nd_ff == ND_W'(DIGIT_BUFFER_DEPTH - 1)));
      status.out_free  = out_free;
      status.total_one = (total_ff == LEN_W'(1));

      status.seg_busy            = '0;
      status.seg_busy[SEG_LEAD]  = (pad_ff != '0) && !zero_ff && !left_ff;
      status.seg_busy[SEG_SIGN]  = has_sign_ff;
      status.seg_busy[SEG_PFX0]  = (alt_len_ff != 2'd0);
      status.seg_busy[SEG_PFX1]  = (alt_len_ff == 2'd2);
      status.seg_busy[SEG_ZPAD]  = (pad_ff != '0) && zero_ff;
      status.seg_busy[SEG_PZERO] = (pz_ff != '0);
      status.seg_busy[SEG_DIGIT] = (nd_ff != '0);
      status.seg_busy[SEG_TRAIL] = (pad_ff != '0) && left_ff;

      status.seg_end            = '0;
      status.seg_end[SEG_LEAD]  = (pad_ff == LEN_W'(1));
      status.seg_end[SEG_SIGN]  = 1'b1;
      status.seg_end[SEG_PFX0]  = 1'b1;
      status.seg_end[SEG_PFX1]  = 1'b1;
      status.seg_end[SEG_ZPAD]  = (pad_ff == LEN_W'(1));
      status.seg_end[SEG_PZERO] = (pz_ff == LEN_W'(1));
      status.seg_end[SEG_DIGIT] = (nd_ff == ND_W'(1));
      status.seg_end[SEG_TRAIL] = (pad_ff == LEN_W'(1));
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = text_ff;
   assign rsp_last_char = last_ff;
   assign rsp_bad_base  = bad_ff;

endmodule

### rtl/integer_to_text_formatter.sv
`timescale 1ns / 1ps
// Top level of the printf-style integer to text formatter.
// Depends on itf_pkg, itf_ctrl and itf_datapath.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  value, base, width, precision, format_flags
//   rsp_      out         rsp_valid / rsp_stall  text_char, last_char, bad_base
//
// One item at a time. The shared divider yields 8 quotient bits a cycle and produces
// the d digits in turn; the plan and start states follow, then one character a cycle
// while not stalled, n characters in all (d <= 32, n <= 63); bad base takes one beat.
// req_stall stays high from acceptance until the last beat is in the result register.
// rsp_stall holds the result register and pauses character output.
// Reset is synchronous and clears the controller and the result valid; no clearing pass.
module integer_to_text_formatter #(
   parameter int MAX_FIELD          = 60,
   parameter int DIGIT_BUFFER_DEPTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic        [itf_pkg::VALUE_W-1:0]  req_value,
   input  logic        [itf_pkg::BASE_W-1:0]   req_base,
   input  logic signed [itf_pkg::LEN_IN_W-1:0] req_width,
   input  logic signed [itf_pkg::LEN_IN_W-1:0] req_precision,
   input  logic        [itf_pkg::FLAGS_W-1:0]  req_format_flags,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic        [itf_pkg::CHAR_W-1:0]   rsp_text_char,
   output logic                               rsp_last_char,
   output logic                               rsp_bad_base
);
   import itf_pkg::*;

   itf_cmd_type    cmd;
   itf_status_type status;

   itf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   itf_datapath #(
      .MAX_FIELD          (MAX_FIELD),
      .DIGIT_BUFFER_DEPTH (DIGIT_BUFFER_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_value        (req_value),
      .req_base         (req_base),
      .req_width        (req_width),
      .req_precision    (req_precision),
      .req_format_flags (req_format_flags),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_text_char    (rsp_text_char),
      .rsp_last_char    (rsp_last_char),
      .rsp_bad_base     (rsp_bad_base)
   );

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.emit_bad) |-> (!rsp_valid || !rsp_stall))
      else $error("result register written while holding a stalled beat");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after accepting a beat");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      ((cmd.emit || cmd.emit_bad) && cmd.last) |=> !req_stall)
      else $error("not ready for a new beat after the last character");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !(cmd.emit || cmd.emit_bad || cmd.div_step || cmd.plan))
      else $error("datapath commanded while idle");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_text_formatter: directed and random conversions
// under varied beat pacing, each output character checked against a built-in predictor.
// Depends on itf_pkg and the formatter RTL.

typedef struct packed {
   logic [7:0] text_char;
   logic       last_char;
   logic       bad_base;
} text_beat_type;

class char_scoreboard;
   localparam int MAX_FIELD   = 60;
   localparam int PRINT_LIMIT = 40;

   string         upper_digits = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
   string         lower_digits = "0123456789abcdefghijklmnopqrstuvwxyz";
   text_beat_type expected_text[$];
   int            errors;
   int            conversions;
   int            bad_bases;
   int            beats;

   function int field_len(logic [6:0] raw);
      if (raw[6]) begin
         return -1;
      end
      if (raw > MAX_FIELD) begin
         return MAX_FIELD;
      end
      return int'(raw);
   endfunction

   function void note_conversion(logic [31:0] value, logic [5:0] base, logic [6:0] width_raw,
                                 logic [6:0] prec_raw, logic [6:0] flags);
      logic [7:0]  chars[$];
      logic [7:0]  digits[$];
      logic [31:0] mag;
      logic [7:0]  sign_ch;
      logic        lower;
      logic        left;
      logic        zero;
      logic        alt;
      int          field;
      int          prec;
      int          pad_n;
      int          d;
      int          i;
      conversions++;
      if (base < itf_pkg::BASE_MIN || base > itf_pkg::BASE_MAX) begin
         bad_bases++;
         expected_text.push_back('{8'h00, 1'b1, 1'b1});
         return;
      end
      lower   = flags[itf_pkg::FL_LOWER];
      left    = flags[itf_pkg::FL_LEFT];
      zero    = flags[itf_pkg::FL_ZERO] && !left;
      alt     = flags[itf_pkg::FL_ALT];
      mag     = value;
      sign_ch = 8'h00;
      if (flags[itf_pkg::FL_SIGN] && value[31]) begin
         sign_ch = "-";
         mag     = 32'd0 - value;
      end else if (flags[itf_pkg::FL_PLUS]) begin
         sign_ch = "+";
      end else if (flags[itf_pkg::FL_SPACE]) begin
         sign_ch = " ";
      end
      field = field_len(width_raw);
      prec  = field_len(prec_raw);
      if (sign_ch != 8'h00) begin
         field--;
      end
      if (alt && base == itf_pkg::BASE_HEX) begin
         field -= 2;
      end else if (alt && base == itf_pkg::BASE_OCT) begin
         field--;
      end
      if (mag == 0) begin
         digits.push_back("0");
      end
      while (mag != 0) begin
         d = int'(mag % 32'(base));
         digits.push_back(lower ? lower_digits[d] : upper_digits[d]);
         mag = mag / 32'(base);
      end
      if (digits.size() > prec) begin
         prec = digits.size();
      end
      field -= prec;
      pad_n = (field > 0) ? field : 0;
      if (!zero && !left) begin
         repeat (pad_n) chars.push_back(" ");
      end
      if (sign_ch != 8'h00) begin
         chars.push_back(sign_ch);
      end
      if (alt && base == itf_pkg::BASE_OCT) begin
         chars.push_back("0");
      end else if (alt && base == itf_pkg::BASE_HEX) begin
         chars.push_back("0");
         chars.push_back(lower ? lower_digits[33] : upper_digits[33]);
      end
      if (zero) begin
         repeat (pad_n) chars.push_back("0");
      end
      repeat (prec - digits.size()) chars.push_back("0");
      for (i = digits.size() - 1; i >= 0; i--) begin
         chars.push_back(digits[i]);
      end
      if (left) begin
         repeat (pad_n) chars.push_back(" ");
      end
      for (i = 0; i < chars.size(); i++) begin
         expected_text.push_back('{chars[i], i == chars.size() - 1, 1'b0});
      end
   endfunction

   function void mismatch(string name, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= PRINT_LIMIT) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   function void check_beat(logic [7:0] text_char, logic last_char, logic bad_base);
      text_beat_type want;
      if (expected_text.size() == 0) begin
         errors++;
         if (errors <= PRINT_LIMIT) begin
            $display("%0t: unexpected beat, expected none, actual char %h last %b bad %b",
                     $time, text_char, last_char, bad_base);
         end
         return;
      end
      want = expected_text.pop_front();
      beats++;
      if (text_char !== want.text_char) begin
         mismatch("text_char", want.text_char, text_char);
      end
      if (last_char !== want.last_char) begin
         mismatch("last_char", 8'(want.last_char), 8'(last_char));
      end
      if (bad_base !== want.bad_base) begin
         mismatch("bad_base", 8'(want.bad_base), 8'(bad_base));
      end
   endfunction

   function void close_out();
      if (expected_text.size() != 0) begin
         $display("%0t: %0d expected characters never arrived", $time, expected_text.size());
         errors += expected_text.size();
      end
   endfunction
endclass

module testbench;
   import itf_pkg::*;

   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 200;
   localparam int PHASE_ITEMS  = 105;

   localparam logic [6:0] NONE    = 7'h7F;
   localparam logic [6:0] F_ZERO  = 7'(1 << FL_ZERO);
   localparam logic [6:0] F_SIGN  = 7'(1 << FL_SIGN);
   localparam logic [6:0] F_PLUS  = 7'(1 << FL_PLUS);
   localparam logic [6:0] F_SPACE = 7'(1 << FL_SPACE);
   localparam logic [6:0] F_LEFT  = 7'(1 << FL_LEFT);
   localparam logic [6:0] F_ALT   = 7'(1 << FL_ALT);
   localparam logic [6:0] F_LOWER = 7'(1 << FL_LOWER);

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic        [VALUE_W-1:0]  req_value = '0;
   logic        [BASE_W-1:0]   req_base = '0;
   logic signed [LEN_IN_W-1:0] req_width = '0;
   logic signed [LEN_IN_W-1:0] req_precision = '0;
   logic        [FLAGS_W-1:0]  req_format_flags = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic        [CHAR_W-1:0]   rsp_text_char;
   logic                       rsp_last_char;
   logic                       rsp_bad_base;

   int             send_idle_pct = 0;
   int             stall_pct = 0;
   int             holds_asked = 0;
   int             idle_cycles = 0;
   char_scoreboard board = new();

   integer_to_text_formatter #(
      .MAX_FIELD         (60),
      .DIGIT_BUFFER_DEPTH(32)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_base        (req_base),
      .req_width       (req_width),
      .req_precision   (req_precision),
      .req_format_flags(req_format_flags),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_text_char   (rsp_text_char),
      .rsp_last_char   (rsp_last_char),
      .rsp_bad_base    (rsp_bad_base)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin : receiver
      int holds_done;
      int held;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (holds_done < holds_asked) begin
            holds_done++;
            for (held = 0; held < HOLD_CYCLES; held++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            board.check_beat(rsp_text_char, rsp_last_char, rsp_bad_base);
         end
         if (req_valid && !req_stall) begin
            board.note_conversion(req_value, req_base, req_width, req_precision,
                                  req_format_flags);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: timeout, no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic send_item(input logic [31:0] value, input logic [5:0] base,
                            input logic [6:0] width_raw, input logic [6:0] prec_raw,
                            input logic [6:0] flags);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_value        <= value;
      req_base         <= base;
      req_width        <= width_raw;
      req_precision    <= prec_raw;
      req_format_flags <= flags;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_text();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_text.size() != 0) @(posedge clock);
   endtask

   function automatic logic [6:0] random_len();
      int pick;
      pick = $urandom_range(99);
      if (pick < 30) begin
         return NONE;
      end
      if (pick < 40) begin
         return 7'($urandom_range(127, 64));
      end
      if (pick < 85) begin
         return 7'($urandom_range(20));
      end
      return 7'($urandom_range(63));
   endfunction

   task automatic send_random();
      logic [31:0] value;
      logic [5:0]  base;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         value = '0;
      end else if (pick < 35) begin
         value = $urandom_range(255);
      end else if (pick < 50) begin
         value = $urandom_range(1) ? (32'h8000_0000 | $urandom_range(255))
                                   : ~32'($urandom_range(255));
      end else if (pick < 70) begin
         value = $urandom >> $urandom_range(31);
      end else begin
         value = $urandom;
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
         base = 6'($urandom_range(63));
      end else if (pick < 50) begin
         case ($urandom_range(3))
            0: base = 6'd2;
            1: base = BASE_OCT;
            2: base = 6'd10;
            default: base = BASE_HEX;
         endcase
      end else begin
         base = 6'($urandom_range(36, 2));
      end
      send_item(value, base, random_len(), random_len(), 7'($urandom_range(127)));
   endtask

   initial begin : stimulus
      int phase;
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(32'h0000_0000, 6'd10, NONE, NONE, 7'h00);
      send_item(32'h0000_0000, 6'd10, NONE, 7'd0, 7'h00);
      send_item(32'h0000_0000, 6'd10, NONE, 7'd5, F_ZERO);
      send_item(32'hFFFF_FFFF, 6'd2, NONE, NONE, 7'h00);
      send_item(32'h8000_0000, 6'd10, NONE, NONE, F_SIGN);
      send_item(32'hFFFF_FFFF, BASE_MAX, NONE, NONE, F_LOWER);
      send_item(32'd12345, 6'd0, 7'd10, NONE, 7'h00);
      send_item(32'd12345, 6'd1, NONE, NONE, F_ALT);
      send_item(32'd12345, 6'd37, NONE, NONE, 7'h00);
      send_item(32'hFFFF_FFFF, 6'd63, 7'd63, 7'd63, 7'h7F);
      send_item(32'd255, BASE_HEX, 7'd10, NONE, F_ALT | F_ZERO);
      send_item(32'd255, BASE_HEX, NONE, NONE, F_ALT | F_LOWER);
      send_item(32'd8, BASE_OCT, NONE, NONE, F_ALT);
      send_item(32'd0, BASE_OCT, 7'd4, NONE, F_ALT);
      send_item(32'd5, 6'd10, 7'd3, NONE, F_ALT);
      send_item(32'd42, 6'd10, 7'd8, NONE, F_LEFT | F_ZERO);
      send_item(32'd42, 6'd10, NONE, NONE, F_PLUS | F_SPACE);
      send_item(-32'sd7, 6'd10, 7'd5, NONE, F_SIGN | F_PLUS | F_SPACE);
      send_item(32'd42, 6'd10, NONE, NONE, F_SPACE);
      send_item(32'd1, 6'd10, 7'd63, NONE, 7'h00);
      send_item(32'h8000_0001, BASE_HEX, 7'd63, 7'd63, F_SIGN | F_ALT | F_ZERO);
      send_item(32'd77, 6'd10, 7'h40, 7'h7E, F_ZERO);
      send_item(32'd9, BASE_OCT, 7'd60, 7'd3, F_LEFT | F_ALT);
      send_item(32'hDEAD_BEEF, 6'd2, 7'd60, NONE, F_ZERO | F_PLUS);
      drain_text();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 88; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 88; end
            default: begin send_idle_pct = 31; stall_pct = 31; end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // long hold-off on the result side while beats keep coming in
            if (phase == 0 && n == 20) begin
               holds_asked++;
            end
            if (phase == 1 && n == 50) begin
               drain_text();
            end
            send_random();
         end
         drain_text();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      board.close_out();
      $display("Covered %0d conversions (%0d with a rejected base), %0d characters checked,",
               board.conversions, board.bad_bases, board.beats);
      $display("over directed cases, four pacing phases and a %0d-cycle result hold-off.",
               HOLD_CYCLES);
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
